// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on the rising clock edge, switched off during reset.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Assertion sampled on the rising clock edge, also live during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== rtl/ecwd_pkg.sv =====
// ----------------------------------------------------------------------------
// ecwd_pkg
// Types, codes and constants of the event-camera word decoder.
// ----------------------------------------------------------------------------
package ecwd_pkg;

  localparam int TIME_WIDTH_DEFAULT = 64;
  localparam int OUT_TIME_WIDTH     = 64;
  localparam int CFG_INDEX_WIDTH    = 2;
  localparam int CFG_DATA_WIDTH     = 13;
  localparam int ADDR_WIDTH         = 12;

  localparam logic [CFG_DATA_WIDTH-1:0] COLUMNS_RESET = 13'd346;
  localparam logic [CFG_DATA_WIDTH-1:0] ROWS_RESET    = 13'd260;

  localparam logic [ADDR_WIDTH-1:0] SPECIAL_CLEAR_TIME = 12'h001;

  typedef enum logic [2:0] {
    CODE_SPECIAL = 3'd0,
    CODE_Y       = 3'd1,
    CODE_X_DEC   = 3'd2,
    CODE_X_INC   = 3'd3,
    CODE_APS     = 3'd4,
    CODE_MISC8   = 3'd5,
    CODE_MISC10  = 3'd6,
    CODE_WRAP    = 3'd7
  } word_code_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_COLUMNS = 2'd0,
    REG_ROWS    = 2'd1,
    REG_SWAP    = 2'd2
  } reg_index_t;

  // Time-base update request from the decoder.
  typedef struct packed {
    logic        clear;
    logic        ts_load;
    logic        wrap_load;
    logic [14:0] ts_low;
    logic [11:0] wrap_count;
  } time_ctl_t;

  // One polarity event as held in the result register.
  typedef struct packed {
    logic [ADDR_WIDTH-1:0]     x;
    logic [ADDR_WIDTH-1:0]     y;
    logic                      polarity;
    logic [OUT_TIME_WIDTH-1:0] stamp;
  } event_t;

endpackage

// ===== rtl/ecwd_timebase.sv =====
// ----------------------------------------------------------------------------
// ecwd_timebase
// Wrap base, current time and zero point; gives the rebased event time.
// ----------------------------------------------------------------------------
module ecwd_timebase #(
  parameter int TIME_WIDTH = ecwd_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  ecwd_pkg::time_ctl_t                      ctl,
  output logic                                     time_valid,
  output logic [ecwd_pkg::OUT_TIME_WIDTH-1:0]      rebased
);
  import ecwd_pkg::*;

  logic [TIME_WIDTH-1:0] wrap_base;
  logic [TIME_WIDTH-1:0] current_time;
  logic [TIME_WIDTH-1:0] time_zero;
  logic [TIME_WIDTH-1:0] ts_sum;
  logic [TIME_WIDTH-1:0] wrap_sum;
  logic [TIME_WIDTH-1:0] diff;

  assign ts_sum   = wrap_base + TIME_WIDTH'(ctl.ts_low);
  assign wrap_sum = wrap_base + TIME_WIDTH'({ctl.wrap_count, 15'd0});
  assign diff     = current_time - time_zero;
  assign rebased  = OUT_TIME_WIDTH'(signed'(diff));

  always_ff @(posedge clk) begin
    if (rst) begin
      time_valid   <= 1'b0;
      time_zero    <= '0;
      wrap_base    <= '0;
      current_time <= '0;
    end else if (ctl.clear) begin
      time_valid   <= 1'b0;
      wrap_base    <= '0;
      current_time <= '0;
    end else if (ctl.ts_load) begin
      current_time <= ts_sum;
      if (!time_valid) begin
        time_valid <= 1'b1;
        time_zero  <= ts_sum;
      end
    end else if (ctl.wrap_load) begin
      wrap_base    <= wrap_sum;
      current_time <= wrap_sum;
      if (!time_valid) begin
        time_valid <= 1'b1;
        time_zero  <= wrap_sum;
      end
    end
  end

endmodule

// ===== rtl/ecwd_result_reg.sv =====
// ----------------------------------------------------------------------------
// ecwd_result_reg
// Output register holding one event until the consumer takes it.
// ----------------------------------------------------------------------------
module ecwd_result_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  ecwd_pkg::event_t load_event,
  input  logic             ready,
  output logic             valid,
  output ecwd_pkg::event_t held_event
);
  import ecwd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_event <= load_event;
    end
  end

endmodule

// ===== rtl/event_camera_word_decoder.sv =====
// ----------------------------------------------------------------------------
// event_camera_word_decoder
// Decodes a 16-bit event-camera address-event stream into polarity events.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  word     | word_valid, word_ready, word             | in
//  event    | event_valid, event_ready, event_x,       | out
//           | event_y, polarity, event_time            |
//  config   | cfg_write, cfg_index, cfg_data           | in
//
//  One word per cycle sustained unless an event waits on a full result
//  register. A word is held in the input register, is decoded there and
//  updates the time base, and its event is loaded into the result register.
//  The time base holds three TIME_WIDTH-bit adders working in parallel.
//  rst is synchronous and clears control and time state and the config registers.
//  A stalled event holds only an emitting X word, and the words behind it.
// ----------------------------------------------------------------------------
module event_camera_word_decoder #(
  parameter int TIME_WIDTH = ecwd_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [ecwd_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [ecwd_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  input  logic                                   word_valid,
  output logic                                   word_ready,
  input  logic [15:0]                            word,
  output logic                                   event_valid,
  input  logic                                   event_ready,
  output logic [ecwd_pkg::ADDR_WIDTH-1:0]        event_x,
  output logic [ecwd_pkg::ADDR_WIDTH-1:0]        event_y,
  output logic                                   polarity,
  output logic signed [ecwd_pkg::OUT_TIME_WIDTH-1:0] event_time
);
  import ecwd_pkg::*;

  // Configuration registers
  logic [CFG_DATA_WIDTH-1:0] sensor_columns;
  logic [CFG_DATA_WIDTH-1:0] sensor_rows;
  logic                      swap_axes;

  // Input register
  logic        word_full;
  logic [15:0] word_q;

  // Row latched by the last Y word
  logic [ADDR_WIDTH-1:0] latched_row;

  word_code_t            code;
  logic [ADDR_WIDTH-1:0] data;
  logic                  is_stamp;
  logic                  is_x;
  logic                  emit;
  logic                  step;
  logic                  result_free;
  logic                  time_valid;
  logic [OUT_TIME_WIDTH-1:0] rebased;
  time_ctl_t             ctl;
  event_t                new_event;
  event_t                held_event;

  // Write the configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_columns <= COLUMNS_RESET;
      sensor_rows    <= ROWS_RESET;
      swap_axes      <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COLUMNS: sensor_columns <= cfg_data;
        REG_ROWS:    sensor_rows    <= cfg_data;
        REG_SWAP:    swap_axes      <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  // Split the held word into its fields.
  assign is_stamp = word_q[15];
  assign code     = word_code_t'(word_q[14:12]);
  assign data     = word_q[11:0];

  // Only X words produce a transaction.
  assign is_x = !is_stamp && (code inside {CODE_X_DEC, CODE_X_INC});

  // Decode: every word other than an X word only touches state and so
  // never waits on the output side.
  always_comb begin
    ctl            = '0;
    ctl.ts_low     = word_q[14:0];
    ctl.wrap_count = data;
    if (is_stamp) begin
      ctl.ts_load = step;
    end else begin
      unique case (code)
        CODE_SPECIAL:          ctl.clear     = step && (data == SPECIAL_CLEAR_TIME);
        CODE_WRAP:             ctl.wrap_load = step;
        default:               ;
      endcase
    end
  end

  // Range check against the configured sensor size, before any swap.
  assign emit = word_full && is_x && time_valid
             && ({1'b0, data} < sensor_columns)
             && ({1'b0, latched_row} < sensor_rows);

  // Advance the held word unless it carries an event and the result
  // register is still occupied.
  assign result_free = !event_valid || event_ready;
  assign step        = word_full && (!emit || result_free);
  assign word_ready  = !word_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_full <= 1'b0;
    end else if (word_ready) begin
      word_full <= word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (word_valid && word_ready) begin
      word_q <= word;
    end
  end

  // Latch the row on a Y word.
  always_ff @(posedge clk) begin
    if (rst) begin
      latched_row <= '0;
    end else if (step && !is_stamp && code == CODE_Y) begin
      latched_row <= data;
    end
  end

  ecwd_timebase #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_timebase (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .time_valid (time_valid),
    .rebased    (rebased)
  );

  // Build the event, swapping the axes if asked to.
  always_comb begin
    new_event.x        = swap_axes ? latched_row : data;
    new_event.y        = swap_axes ? data : latched_row;
    new_event.polarity = word_q[12];
    new_event.stamp    = rebased;
  end

  ecwd_result_reg u_result (
    .clk        (clk),
    .rst        (rst),
    .load       (step && emit),
    .load_event (new_event),
    .ready      (event_ready),
    .valid      (event_valid),
    .held_event (held_event)
  );

  assign event_x    = held_event.x;
  assign event_y    = held_event.y;
  assign polarity   = held_event.polarity;
  assign event_time = signed'(held_event.stamp);

endmodule

// ===== rtl/ecwd_checker.sv =====
// ----------------------------------------------------------------------------
// ecwd_checker
// Port-level checks on the event-camera word decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ecwd_checker (
  input logic        clk,
  input logic        rst,
  input logic        word_valid,
  input logic        word_ready,
  input logic        event_valid,
  input logic        event_ready,
  input logic [11:0] event_x,
  input logic [11:0] event_y,
  input logic        polarity,
  input logic [63:0] event_time
);

  logic [88:0] event_payload;

  assign event_payload = {event_x, event_y, polarity, event_time};

  // A stalled event keeps its payload.
  `ASSERT_CLK(a_event_hold, clk, rst, (event_valid && !event_ready) |=> (event_valid && $stable(event_payload)))

  // No event is shown straight after reset.
  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, rst |=> !event_valid)

  // With room on the output side the input side never stalls.
  `ASSERT_CLK(a_ready_when_free, clk, rst, (!event_valid || event_ready) |-> word_ready)

  // A fresh event comes from a word taken through the input register, then the result register.
  `ASSERT_CLK(a_event_source, clk, rst, $rose(event_valid) |-> $past(word_valid && word_ready, 2))

endmodule

bind event_camera_word_decoder ecwd_checker u_ecwd_checker (
  .clk         (clk),
  .rst         (rst),
  .word_valid  (word_valid),
  .word_ready  (word_ready),
  .event_valid (event_valid),
  .event_ready (event_ready),
  .event_x     (event_x),
  .event_y     (event_y),
  .polarity    (polarity),
  .event_time  (event_time)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the event-camera word decoder. Stream words go in
// over a valid/ready channel with random gaps, polarity events come out under
// random back-pressure, and every event is checked against a predicted stream
// built from the decoder's own rules of time base, wrap, row latch and range
// check, across several register settings.
// ----------------------------------------------------------------------------
module tb;
  import ecwd_pkg::*;

  // Index with no register behind it: writes must be ignored.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;

  localparam int WORD_TARGET    = 1800;  // words to offer in total
  localparam int PHASE_WORDS    = 180;   // words per register setting
  localparam int PIPE_SETTLE    = 4;     // cycles to let the two-stage pipe empty
  localparam int LONG_HOLD      = 300;   // receiver hold-off in the first phase
  localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up

  // --------------------------------------------------------------------------
  // Expected event stream: tracks time base, row latch and settings, and
  // queues one event per X word that survives the checks.
  // --------------------------------------------------------------------------
  class event_scoreboard;
    logic [CFG_DATA_WIDTH-1:0] columns;
    logic [CFG_DATA_WIDTH-1:0] rows;
    logic                      swap;
    logic                      base_valid;
    logic [63:0]               zero_point;
    logic [63:0]               wrap_base;
    logic [63:0]               now;
    logic [ADDR_WIDTH-1:0]     row;
    event_t                    pending_events[$];
    int                        errors;

    function new();
      columns    = COLUMNS_RESET;
      rows       = ROWS_RESET;
      swap       = 1'b0;
      base_valid = 1'b0;
      zero_point = '0;
      wrap_base  = '0;
      now        = '0;
      row        = '0;
      errors     = 0;
    endfunction

    function void write_register(logic [CFG_INDEX_WIDTH-1:0] index,
                                 logic [CFG_DATA_WIDTH-1:0] value);
      case (index)
        REG_COLUMNS: columns = value;
        REG_ROWS:    rows    = value;
        REG_SWAP:    swap    = value[0];
        default: ;
      endcase
    endfunction

    // The first time seen with no base becomes the zero point.
    function void set_time(logic [63:0] t);
      if (!base_valid) begin
        base_valid = 1'b1;
        zero_point = t;
      end
      now = t;
    endfunction

    function void note_word(logic [15:0] w);
      word_code_t            code;
      logic [ADDR_WIDTH-1:0] data;
      event_t                ev;
      if (w[15]) begin
        set_time(wrap_base + 64'(w[14:0]));
        return;
      end
      code = word_code_t'(w[14:12]);
      data = w[11:0];
      case (code)
        CODE_SPECIAL: begin
          if (data == SPECIAL_CLEAR_TIME) begin
            wrap_base  = '0;
            now        = '0;
            base_valid = 1'b0;
          end
        end
        CODE_Y: row = data;
        CODE_X_DEC, CODE_X_INC: begin
          if (base_valid && 13'(data) < columns && 13'(row) < rows) begin
            ev.x        = swap ? row : data;
            ev.y        = swap ? data : row;
            ev.polarity = (code == CODE_X_INC);
            ev.stamp    = now - zero_point;
            pending_events = {pending_events, ev};
          end
        end
        CODE_WRAP: begin
          wrap_base = wrap_base + 64'({data, 15'd0});
          set_time(wrap_base);
        end
        default: ;
      endcase
    endfunction

    function void note_fault(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_event(logic [ADDR_WIDTH-1:0] x, logic [ADDR_WIDTH-1:0] y,
                              logic pol, logic [63:0] stamp);
      event_t want;
      if (pending_events.size() == 0) begin
        note_fault($sformatf("unexpected event x=%0d y=%0d pol=%0b t=%0d",
                             x, y, pol, $signed(stamp)));
        return;
      end
      want = pending_events.pop_front();
      if (want.x !== x || want.y !== y || want.polarity !== pol || want.stamp !== stamp)
        note_fault($sformatf("event mismatch: want x=%0d y=%0d pol=%0b t=%0d, got x=%0d y=%0d pol=%0b t=%0d",
                             want.x, want.y, want.polarity, $signed(want.stamp),
                             x, y, pol, $signed(stamp)));
    endfunction

    function int outstanding();
      return pending_events.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test and its drive signals, all known from time zero
  // --------------------------------------------------------------------------
  logic                        clk         = 1'b0;
  logic                        rst         = 1'b1;
  logic                        cfg_write   = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0]  cfg_index   = REG_COLUMNS;
  logic [CFG_DATA_WIDTH-1:0]   cfg_data    = '0;
  logic                        word_valid  = 1'b0;
  logic                        word_ready;
  logic [15:0]                 word        = '0;
  logic                        event_valid;
  logic                        event_ready = 1'b0;
  logic [ADDR_WIDTH-1:0]       event_x;
  logic [ADDR_WIDTH-1:0]       event_y;
  logic                        polarity;
  logic signed [OUT_TIME_WIDTH-1:0] event_time;

  event_camera_word_decoder uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .word_valid  (word_valid),
    .word_ready  (word_ready),
    .word        (word),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .event_x     (event_x),
    .event_y     (event_y),
    .polarity    (polarity),
    .event_time  (event_time)
  );

  always #2 clk = ~clk;

  event_scoreboard           scoreboard;
  int                        words_sent = 0;
  bit                        steady     = 1'b0;  // both sides run without gaps
  int                        hold_request = 0;   // long receiver hold-off asked
  int                        hold_left  = 0;
  int                        ready_wait = 0;
  logic [CFG_DATA_WIDTH-1:0] cur_cols   = COLUMNS_RESET;
  logic [CFG_DATA_WIDTH-1:0] cur_rows   = ROWS_RESET;

  // --------------------------------------------------------------------------
  // Word encoders
  // --------------------------------------------------------------------------
  function automatic logic [15:0] word_of(word_code_t code, logic [ADDR_WIDTH-1:0] data);
    return {1'b0, code, data};
  endfunction

  function automatic logic [15:0] stamp_word(logic [14:0] low);
    return {1'b1, low};
  endfunction

  // Mostly an address inside the sensor, now and then any 12-bit value.
  function automatic logic [ADDR_WIDTH-1:0] pick_address(logic [CFG_DATA_WIDTH-1:0] limit);
    if (limit == 0 || limit > 13'd4096 || $urandom_range(0, 9) == 0)
      return ADDR_WIDTH'($urandom);
    return ADDR_WIDTH'($urandom_range(0, limit - 1));
  endfunction

  // --------------------------------------------------------------------------
  // Word channel: offer one word after a random gap, hold it until the
  // transaction completes, then record it in the prediction
  // --------------------------------------------------------------------------
  task automatic send_word(input logic [15:0] w);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      word_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word_valid <= 1'b1;
    word       <= w;
    do @(posedge clk); while (!word_ready);
    scoreboard.note_word(w);
    words_sent++;
  endtask

  // Drop valid and wait until every predicted event has arrived, then give
  // the pipe time to retire words that produce nothing.
  task automatic settle();
    word_valid <= 1'b0;
    while (scoreboard.outstanding() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic program_register(input logic [CFG_INDEX_WIDTH-1:0] index,
                                  input logic [CFG_DATA_WIDTH-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    scoreboard.write_register(index, value);
  endtask

  // Write every register back to back, plus the spare index with junk.
  task automatic apply_settings(input logic [CFG_DATA_WIDTH-1:0] cols,
                                input logic [CFG_DATA_WIDTH-1:0] rows,
                                input logic [CFG_DATA_WIDTH-1:0] swap_data);
    program_register(REG_COLUMNS, cols);
    program_register(REG_ROWS, rows);
    program_register(REG_SWAP, swap_data);
    program_register(REG_SPARE, CFG_DATA_WIDTH'($urandom));
    cfg_write <= 1'b0;
    cur_cols = cols;
    cur_rows = rows;
  endtask

  // Directed opening under reset settings (346 columns, 260 rows, no swap).
  task automatic send_opening_words();
    send_word(word_of(CODE_Y, 12'd0));
    send_word(word_of(CODE_X_DEC, 12'd5));            // no time base yet: drop
    send_word(word_of(CODE_SPECIAL, 12'd0));          // other special data: ignore
    send_word(word_of(CODE_SPECIAL, 12'hFFF));
    send_word(stamp_word(15'h0100));                  // becomes the zero point
    send_word(word_of(CODE_X_DEC, 12'd0));
    send_word(stamp_word(15'h0000));                  // earlier than zero: negative time
    send_word(word_of(CODE_X_INC, 12'd345));          // last column in range
    send_word(word_of(CODE_Y, 12'd259));              // last row in range
    send_word(stamp_word(15'h7FFF));
    send_word(word_of(CODE_X_INC, 12'd345));
    send_word(word_of(CODE_X_DEC, 12'd346));          // column out of range
    send_word(word_of(CODE_Y, 12'd260));
    send_word(word_of(CODE_X_DEC, 12'd0));            // row out of range
    send_word(word_of(CODE_Y, 12'hFFF));
    send_word(word_of(CODE_X_INC, 12'hFFF));
    send_word(word_of(CODE_WRAP, 12'hFFF));           // largest wrap step
    send_word(word_of(CODE_APS, 12'hABC));
    send_word(word_of(CODE_MISC8, 12'h555));
    send_word(word_of(CODE_MISC10, 12'hFFF));
    send_word(word_of(CODE_Y, 12'd3));
    send_word(word_of(CODE_X_INC, 12'd7));
    send_word(word_of(CODE_WRAP, 12'd0));
    send_word(word_of(CODE_SPECIAL, SPECIAL_CLEAR_TIME));
    send_word(word_of(CODE_X_DEC, 12'd7));            // base cleared: drop
    send_word(word_of(CODE_WRAP, 12'd3));             // wrap sets the new zero point
    send_word(word_of(CODE_X_INC, 12'd1));
    send_word(stamp_word(15'h0005));
    send_word(word_of(CODE_X_DEC, 12'd2));
  endtask

  // One random chunk of stream: mostly timestamp, rows and X words in the
  // order a sensor sends them, the rest clears, wraps, ignored codes and noise.
  task automatic send_packet();
    int pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) steady = ~steady;
    if (pick < 2) begin
      send_word(word_of(CODE_SPECIAL, SPECIAL_CLEAR_TIME));
    end else if (pick < 8) begin
      send_word(16'($urandom));
    end else if (pick < 12) begin
      send_word(word_of(word_code_t'($urandom_range(CODE_APS, CODE_MISC10)),
                        ADDR_WIDTH'($urandom)));
    end else if (pick < 15) begin
      send_word(word_of(CODE_SPECIAL, ADDR_WIDTH'($urandom)));
    end else if (pick < 22) begin
      send_word(word_of(CODE_WRAP, $urandom_range(0, 1) ? ADDR_WIDTH'($urandom)
                                                         : ADDR_WIDTH'($urandom_range(0, 15))));
    end else begin
      send_word(stamp_word(15'($urandom)));
      repeat ($urandom_range(1, 3)) begin
        send_word(word_of(CODE_Y, pick_address(cur_rows)));
        repeat ($urandom_range(1, 4))
          send_word(word_of($urandom_range(0, 1) ? CODE_X_INC : CODE_X_DEC,
                            pick_address(cur_cols)));
      end
    end
  endtask

  // Register value for a random phase: mostly a real sensor size, sometimes
  // zero (drop all) or above 4096 (pass all).
  function automatic logic [CFG_DATA_WIDTH-1:0] pick_size();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick < 3)  return CFG_DATA_WIDTH'($urandom_range(4097, 8191));
    return CFG_DATA_WIDTH'($urandom_range(1, 4096));
  endfunction

  // --------------------------------------------------------------------------
  // Event channel: check each completed transaction, then hold ready low for
  // a random wait, or for the long hold-off when one is asked
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (event_valid && event_ready) begin
        scoreboard.check_event(event_x, event_y, polarity, event_time);
        ready_wait = steady ? 0 : $urandom_range(0, 3);
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        event_ready <= 1'b0;
      end else if (ready_wait > 0) begin
        ready_wait--;
        event_ready <= 1'b0;
      end else begin
        event_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: give up after a long stretch with no transaction on either side
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (word_valid && word_ready) || (event_valid && event_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("FAIL event_camera_word_decoder");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    int phase;
    int phase_end;
    logic [CFG_DATA_WIDTH-1:0] cols;
    logic [CFG_DATA_WIDTH-1:0] rows;
    logic [CFG_DATA_WIDTH-1:0] swap_data;

    scoreboard = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings first, so their reset values are exercised too.
    send_opening_words();

    for (phase = 0; words_sent < WORD_TARGET; phase++) begin
      // Pause the sender until the pipe is empty before touching registers.
      settle();
      case (phase)
        0: begin cols = 13'd4096; rows = 13'd4096; swap_data = 13'd1;    end
        1: begin cols = 13'd1;    rows = 13'd1;    swap_data = 13'd0;    end
        2: begin cols = 13'd0;    rows = 13'd8191; swap_data = 13'h1FFF; end
        3: begin cols = 13'd8191; rows = 13'd0;    swap_data = 13'h1FFE; end
        default: begin
          cols      = pick_size();
          rows      = pick_size();
          swap_data = CFG_DATA_WIDTH'($urandom);
        end
      endcase
      apply_settings(cols, rows, swap_data);

      // Stall the receiver for a long while so the decoder fills and backs
      // up into the word channel while words keep coming.
      if (phase == 0) hold_request = LONG_HOLD;

      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) send_packet();
    end

    settle();
    if (scoreboard.errors == 0 && scoreboard.outstanding() == 0)
      $display("PASS event_camera_word_decoder");
    else
      $display("FAIL event_camera_word_decoder");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ecwd_pkg.sv
rtl/ecwd_timebase.sv
rtl/ecwd_result_reg.sv
rtl/event_camera_word_decoder.sv
rtl/ecwd_checker.sv
sim/tb.sv
